### design/mbdc_pkg.sv
// ----------------------------------------------------------------------------
// mbdc_pkg: shared types and constants for the muon burst deframer
// Word-pair input type, classified item type, result type and status codes.
// ----------------------------------------------------------------------------
package mbdc_pkg;

	localparam int BurstLenDefault   = 20;
	localparam int QueueDepthDefault = 4;

	localparam logic [31:0] HeaderFlag = 32'h8000_0000;
	localparam logic [30:0] TagMask    = 31'h7fff_ffff;
	localparam logic [5:0]  SampleMax  = 6'd63;

	typedef enum logic [1:0] {
		ST_HEADER = 2'd0,
		ST_SAMPLE = 2'd1,
		ST_ORPHAN = 2'd2,
		ST_EXTRA  = 2'd3
	} status_t;

	typedef struct packed {
		logic [31:0] word_lo;
		logic [31:0] word_hi;
		logic        buffer_end;
	} in_t;

	// Word pair after classification, as held between front and back
	typedef struct packed {
		logic        is_header;
		logic [30:0] time_tag;
		logic [30:0] trigger_tag;
		logic [11:0] adc_a;
		logic [11:0] adc_b;
		logic [11:0] adc_c;
		logic [11:0] adc_d;
		logic [6:0]  seq_number;
		logic        last;
	} item_t;

	typedef struct packed {
		status_t     status;
		logic [15:0] burst_index;
		logic [5:0]  sample_index;
		logic [30:0] time_tag;
		logic [30:0] trigger_tag;
		logic [11:0] adc_a;
		logic [11:0] adc_b;
		logic [11:0] adc_c;
		logic [11:0] adc_d;
		logic [6:0]  seq_number;
		logic        burst_corrupt;
		logic        burst_complete;
	} out_t;

endpackage

### design/muon_burst_deframe_check.sv
// ----------------------------------------------------------------------------
// muon_burst_deframe_check: muon capture buffer deframer and burst checker
//
//   channel  | handshake         | payload
//   ---------+-------------------+------------------------------------------
//   input    | push / full       | item   : word_lo, word_hi, buffer_end
//   result   | pop / empty       | result : status, indices, tags, ADCs, flags
//
// One word pair per cycle while full is low, one result per pair. A pair is
// classified and written to the input queue on its transfer; the tracker
// moves it into the result queue whenever that queue has room. Reset clears
// counters and both queues at once. A stalled result side fills the result
// queue, then the input queue, then raises full.
// ----------------------------------------------------------------------------
module muon_burst_deframe_check #(
	parameter int BURST_LEN   = mbdc_pkg::BurstLenDefault,
	parameter int QUEUE_DEPTH = mbdc_pkg::QueueDepthDefault
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	output logic           full,
	input  mbdc_pkg::in_t  item,
	output logic           empty,
	input  logic           pop,
	output mbdc_pkg::out_t result
);

	import mbdc_pkg::*;

	item_t cls;
	item_t head;
	out_t  res;
	logic  head_empty;
	logic  res_full;
	logic  advance;

	mbdc_front u_front (
		.item (item),
		.cls  (cls)
	);

	mbdc_queue #(
		.T     (item_t),
		.DEPTH (QUEUE_DEPTH)
	) u_in_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (cls),
		.full   (full),
		.pop    (advance),
		.rdata  (head),
		.empty  (head_empty)
	);

	// advance the tracker only when there is room for its result
	assign advance = !head_empty && !res_full;

	mbdc_back #(
		.BURST_LEN (BURST_LEN)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.cls     (head),
		.res     (res)
	);

	mbdc_queue #(
		.T     (out_t),
		.DEPTH (QUEUE_DEPTH)
	) u_out_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (advance),
		.wdata  (res),
		.full   (res_full),
		.pop    (pop),
		.rdata  (result),
		.empty  (empty)
	);

endmodule

### design/mbdc_queue.sv
// ----------------------------------------------------------------------------
// mbdc_queue: small first-in first-out queue
// Register-array queue with push/full and pop/empty sides, any entry type.
// ----------------------------------------------------------------------------
module mbdc_queue #(
	parameter type T     = logic,
	parameter int  DEPTH = 4
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  T     wdata,
	output logic full,
	input  logic pop,
	output T     rdata,
	output logic empty
);

	localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CntW = $clog2(DEPTH + 1);

	T                mem [DEPTH];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;
	logic            do_push;
	logic            do_pop;

	assign full    = (count_q == CntW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

### design/mbdc_front.sv
// ----------------------------------------------------------------------------
// mbdc_front: word-pair classifier
// Splits a word pair into header tags or ADC samples and sequence number.
// ----------------------------------------------------------------------------
module mbdc_front (
	input  mbdc_pkg::in_t   item,
	output mbdc_pkg::item_t cls
);

	import mbdc_pkg::*;

	always_comb begin
		cls             = '0;
		cls.is_header   = (item.word_lo & HeaderFlag) != '0;
		cls.last        = item.buffer_end;
		if (cls.is_header) begin
			cls.time_tag    = item.word_lo[30:0] & TagMask;
			cls.trigger_tag = item.word_hi[30:0] & TagMask;
		end else begin
			cls.adc_a      = item.word_lo[11:0];
			cls.adc_b      = item.word_lo[27:16];
			cls.adc_c      = item.word_hi[11:0];
			cls.adc_d      = item.word_hi[27:16];
			// low nibble from bits 15..12, top three bits from 30..28
			cls.seq_number = {item.word_hi[30:28], item.word_hi[15:12]};
		end
	end

endmodule

### design/mbdc_back.sv
// ----------------------------------------------------------------------------
// mbdc_back: burst tracker and sequence checker
// Holds burst and sample counters, checks sequence numbers, forms results.
// ----------------------------------------------------------------------------
module mbdc_back #(
	parameter int BURST_LEN = mbdc_pkg::BurstLenDefault
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            advance,
	input  mbdc_pkg::item_t cls,
	output mbdc_pkg::out_t  res
);

	import mbdc_pkg::*;

	logic [15:0] burst_q;
	logic [5:0]  sample_q;
	logic        corrupt_q;
	logic        seen_q;

	logic [15:0] burst_d;
	logic [5:0]  sample_d;
	logic        corrupt_d;
	logic        seen_d;
	logic        in_burst;
	logic        mismatch;

	assign in_burst = {1'b0, sample_q} < 7'(BURST_LEN - 1);
	assign mismatch = cls.seq_number != ({1'b0, sample_q} + 7'd1);

	always_comb begin
		res       = '0;
		burst_d   = burst_q;
		sample_d  = sample_q;
		corrupt_d = corrupt_q;
		seen_d    = seen_q;
		if (cls.is_header) begin
			burst_d         = seen_q ? burst_q + 16'd1 : 16'd0;
			seen_d          = 1'b1;
			sample_d        = '0;
			corrupt_d       = 1'b0;
			res.status      = ST_HEADER;
			res.burst_index = burst_d;
			res.time_tag    = cls.time_tag;
			res.trigger_tag = cls.trigger_tag;
		end else begin
			res.adc_a      = cls.adc_a;
			res.adc_b      = cls.adc_b;
			res.adc_c      = cls.adc_c;
			res.adc_d      = cls.adc_d;
			res.seq_number = cls.seq_number;
			if (!seen_q) begin
				res.status = ST_ORPHAN;
			end else begin
				res.burst_index  = burst_q;
				res.sample_index = sample_q;
				if (in_burst) begin
					corrupt_d          = corrupt_q | mismatch;
					res.status         = ST_SAMPLE;
					res.burst_complete = {1'b0, sample_q} == 7'(BURST_LEN - 2);
				end else begin
					res.status = ST_EXTRA;
				end
				res.burst_corrupt = corrupt_d;
				// saturate at SampleMax rather than wrap
				if (sample_q != SampleMax) begin
					sample_d = sample_q + 6'd1;
				end
			end
		end
		if (cls.last) begin
			burst_d   = '0;
			sample_d  = '0;
			corrupt_d = 1'b0;
			seen_d    = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			burst_q   <= '0;
			sample_q  <= '0;
			corrupt_q <= 1'b0;
			seen_q    <= 1'b0;
		end else if (advance) begin
			burst_q   <= burst_d;
			sample_q  <= sample_d;
			corrupt_q <= corrupt_d;
			seen_q    <= seen_d;
		end
	end

endmodule

### design/mbdc_check.sv
// ----------------------------------------------------------------------------
// mbdc_check: port-level checks for the muon burst deframer
// Result hold under stall and field consistency per status code.
// ----------------------------------------------------------------------------
module mbdc_check #(
	parameter int BURST_LEN = mbdc_pkg::BurstLenDefault
) (
	input logic           clk,
	input logic           arst_n,
	input logic           empty,
	input logic           pop,
	input mbdc_pkg::out_t result
);

	import mbdc_pkg::*;

	// hold a waiting result until its transfer
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(result))
		else $error("result changed while waiting");

	a_header_fields: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && result.status == ST_HEADER |->
			result.sample_index == '0 && result.seq_number == '0 &&
			!result.burst_corrupt && !result.burst_complete)
		else $error("header carries sample fields");

	a_sample_tags: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && result.status != ST_HEADER |->
			result.time_tag == '0 && result.trigger_tag == '0)
		else $error("sample carries header tags");

	a_complete: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && result.burst_complete |->
			result.status == ST_SAMPLE && result.sample_index == 6'(BURST_LEN - 2))
		else $error("completion off the last checked sample");

	a_orphan: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && result.status == ST_ORPHAN |->
			result.burst_index == '0 && result.sample_index == '0 &&
			!result.burst_corrupt)
		else $error("orphan sample carries burst state");

endmodule

bind muon_burst_deframe_check mbdc_check #(
	.BURST_LEN (BURST_LEN)
) u_mbdc_check (.*);

### tb/sv/deframe_result_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deframe_result_check: result predictor and comparator for the burst deframer
// Watches both queue channels, predicts the result of every accepted word
// pair and compares each accepted result with the oldest pending prediction.
// ----------------------------------------------------------------------------
module deframe_result_check #(
	parameter int BURST_LEN = mbdc_pkg::BurstLenDefault
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  logic           full,
	input  mbdc_pkg::in_t  item,
	input  logic           empty,
	input  logic           pop,
	input  mbdc_pkg::out_t result,
	output int             errors,
	output int             pend,
	output int             checked,
	output int             completes,
	output int             corrupt_completes,
	output int             extras,
	output int             wraps
);
	import mbdc_pkg::*;

	out_t        expected_results[$];
	logic [15:0] burst_idx;
	logic [5:0]  samp_pos;
	logic        burst_bad;
	logic        hdr_open;

	initial begin
		errors            = 0;
		pend              = 0;
		checked           = 0;
		completes         = 0;
		corrupt_completes = 0;
		extras            = 0;
		wraps             = 0;
	end

	function automatic string show(out_t r);
		return $sformatf({"st=%0d burst=%0d smp=%0d time=%h trig=%h adc=%h/%h/%h/%h",
			" seq=%0d bad=%b done=%b"}, r.status, r.burst_index, r.sample_index,
			r.time_tag, r.trigger_tag, r.adc_a, r.adc_b, r.adc_c, r.adc_d,
			r.seq_number, r.burst_corrupt, r.burst_complete);
	endfunction

	task automatic deframe_pair(input in_t p, output out_t r);
		logic [6:0] seq;
		r   = '0;
		seq = {p.word_hi[30:28], p.word_hi[15:12]};
		if (p.word_lo[31]) begin
			if (hdr_open && burst_idx == 16'hffff)
				wraps++;
			burst_idx     = hdr_open ? burst_idx + 16'd1 : 16'd0;
			hdr_open      = 1'b1;
			samp_pos      = '0;
			burst_bad     = 1'b0;
			r.status      = ST_HEADER;
			r.burst_index = burst_idx;
			r.time_tag    = p.word_lo[30:0];
			r.trigger_tag = p.word_hi[30:0];
		end else begin
			r.adc_a      = p.word_lo[11:0];
			r.adc_b      = p.word_lo[27:16];
			r.adc_c      = p.word_hi[11:0];
			r.adc_d      = p.word_hi[27:16];
			r.seq_number = seq;
			if (!hdr_open) begin
				r.status = ST_ORPHAN;
			end else begin
				r.burst_index  = burst_idx;
				r.sample_index = samp_pos;
				if (int'(samp_pos) < BURST_LEN - 1) begin
					if (seq != {1'b0, samp_pos} + 7'd1)
						burst_bad = 1'b1;
					r.status         = ST_SAMPLE;
					r.burst_corrupt  = burst_bad;
					r.burst_complete = (int'(samp_pos) == BURST_LEN - 2);
					if (r.burst_complete) begin
						completes++;
						if (burst_bad)
							corrupt_completes++;
					end
				end else begin
					r.status        = ST_EXTRA;
					r.burst_corrupt = burst_bad;
					extras++;
				end
				// saturate rather than wrap
				if (samp_pos != SampleMax)
					samp_pos++;
			end
		end
		if (p.buffer_end) begin
			burst_idx = '0;
			samp_pos  = '0;
			burst_bad = 1'b0;
			hdr_open  = 1'b0;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		out_t want;
		if (!arst_n) begin
			expected_results.delete();
			burst_idx = '0;
			samp_pos  = '0;
			burst_bad = 1'b0;
			hdr_open  = 1'b0;
		end else begin
			if (pop && !empty) begin
				if (expected_results.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("mismatch: result with nothing pending: %s", show(result));
				end else begin
					want = expected_results.pop_front();
					checked++;
					if (result !== want) begin
						errors++;
						if (errors <= 10) begin
							$display("mismatch on result %0d", checked);
							$display("  expected %s", show(want));
							$display("  actual   %s", show(result));
						end
					end
				end
			end
			if (push && !full) begin
				deframe_pair(item, want);
				expected_results.push_back(want);
			end
		end
		pend = expected_results.size();
	end

endmodule

### tb/sv/muon_burst_deframe_check_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// muon_burst_deframe_check_tb: stimulus and verdict for the burst deframer
// Drives directed and random capture buffers with random idling on both
// sides and relies on the result checker.
// ----------------------------------------------------------------------------
module muon_burst_deframe_check_tb;
	import mbdc_pkg::*;

	localparam int BurstLen    = BurstLenDefault;
	localparam int RandomPairs = 420;
	localparam int StallLimit  = 500;

	logic clk = 1'b0;
	logic arst_n;
	logic push;
	logic full;
	in_t  item;
	logic empty;
	logic pop;
	out_t result;

	int   errors, pend, checked, completes, corrupt_completes, extras, wraps;
	int   sent;
	int   stall_cycles;
	logic gaps_on;
	in_t  plan[$];

	always #5 clk = ~clk;

	muon_burst_deframe_check #(.BURST_LEN(BurstLen)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.item   (item),
		.empty  (empty),
		.pop    (pop),
		.result (result)
	);

	deframe_result_check #(.BURST_LEN(BurstLen)) checker_i (
		.clk               (clk),
		.arst_n            (arst_n),
		.push              (push),
		.full              (full),
		.item              (item),
		.empty             (empty),
		.pop               (pop),
		.result            (result),
		.errors            (errors),
		.pend              (pend),
		.checked           (checked),
		.completes         (completes),
		.corrupt_completes (corrupt_completes),
		.extras            (extras),
		.wraps             (wraps)
	);

	function automatic in_t pair(logic [31:0] lo, logic [31:0] hi, logic last);
		in_t p;
		p.word_lo    = lo;
		p.word_hi    = hi;
		p.buffer_end = last;
		return p;
	endfunction

	// place the sequence number in its two split fields
	function automatic logic [31:0] sample_hi(logic [6:0] seq, logic [31:0] fill);
		logic [31:0] h;
		h        = fill;
		h[15:12] = seq[3:0];
		h[30:28] = seq[6:4];
		return h;
	endfunction

	// called at a falling edge, returns at the falling edge after the transfer
	task automatic send_pair(input in_t p);
		int gap;
		gap = gaps_on ? $urandom_range(0, 3) : 0;
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		item <= p;
		push <= 1'b1;
		do @(posedge clk); while (full);
		@(negedge clk);
		sent++;
	endtask

	task automatic plan_header();
		plan.push_back(pair($urandom | HeaderFlag, $urandom, 1'b0));
	endtask

	task automatic plan_sample(input int pos, input logic orphan);
		logic [6:0] seq;
		seq = (orphan || $urandom_range(0, 15) == 0) ? 7'($urandom) : 7'(pos + 1);
		plan.push_back(pair($urandom & ~HeaderFlag, sample_hi(seq, $urandom), 1'b0));
	endtask

	task automatic flush_plan(input logic last);
		if (plan.size() > 0)
			plan[plan.size() - 1].buffer_end = last;
		foreach (plan[i])
			send_pair(plan[i]);
		plan.delete();
	endtask

	// result side: random pop gaps per transfer
	initial begin : drain
		int gap;
		pop = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			gap = gaps_on ? $urandom_range(0, 3) : 0;
			if (gap > 0) begin
				pop <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			pop <= 1'b1;
			do @(posedge clk); while (empty);
			@(negedge clk);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((push && !full) || (pop && !empty))
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= StallLimit) begin
				$display("watchdog: no transfer for %0d cycles, %0d results pending",
					stall_cycles, pend);
				$display("FAILED: results differ");
				$finish;
			end
		end
	end

	initial begin : stimulus
		int  k, n, nb, len, pick;
		bit  paused;
		arst_n       = 1'b0;
		push         = 1'b0;
		item         = '0;
		gaps_on      = 1'b1;
		sent         = 0;
		stall_cycles = 0;
		paused       = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: orphan samples, tag extremes, one full burst with a bad
		// sequence number, an extra sample and a header closing the buffer
		send_pair(pair(32'h7fff_ffff, 32'hffff_ffff, 1'b0));
		send_pair(pair(32'h0000_0000, 32'h0000_0000, 1'b0));
		send_pair(pair(32'h8000_0000, 32'h0000_0000, 1'b0));
		send_pair(pair(32'hffff_ffff, 32'hffff_ffff, 1'b0));
		for (k = 0; k < BurstLen - 1; k++)
			send_pair(pair(k[0] ? 32'h7fff_ffff : 32'h0,
				sample_hi(k == 7 ? 7'h7f : 7'(k + 1), k[0] ? 32'hffff_ffff : 32'h0),
				1'b0));
		send_pair(pair(32'h0abc_0def, sample_hi(7'd0, 32'h0123_0456), 1'b0));
		send_pair(pair(32'h8123_4567, 32'h0765_4321, 1'b1));

		// random buffers: mostly well-formed bursts, some noise
		n = sent;
		while (sent - n < RandomPairs) begin
			gaps_on = ($urandom_range(0, 3) != 0);
			if ($urandom_range(0, 7) == 0) begin
				repeat ($urandom_range(1, 3))
					send_pair(pair($urandom, $urandom, 1'($urandom_range(0, 1))));
			end else begin
				if ($urandom_range(0, 3) == 0)
					repeat ($urandom_range(1, 2)) plan_sample(0, 1'b1);
				nb = $urandom_range(1, 3);
				repeat (nb) begin
					plan_header();
					pick = $urandom_range(0, 19);
					if (pick == 0)
						len = $urandom_range(65, 70);
					else if (pick <= 3)
						len = $urandom_range(0, BurstLen - 2);
					else if (pick <= 6)
						len = BurstLen - 1 + $urandom_range(1, 4);
					else
						len = BurstLen - 1;
					for (k = 0; k < len; k++)
						plan_sample(k, 1'b0);
				end
				flush_plan($urandom_range(0, 3) != 0);
			end
			// hold off once until the block has drained
			if (!paused && sent - n >= RandomPairs / 2) begin
				paused = 1'b1;
				push <= 1'b0;
				while (pend != 0) @(negedge clk);
				repeat (3) @(negedge clk);
			end
		end

		gaps_on = 1'b1;

		push <= 1'b0;
		while (pend != 0) @(negedge clk);
		repeat (8) @(negedge clk);

		$display("Run covered %0d word pairs, %0d results compared, %0d bursts completed",
			sent, checked, completes);
		$display("  (%0d of them corrupt), %0d extra samples, %0d burst index wraps",
			corrupt_completes, extras, wraps);
		if (errors == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
